FILE: sv/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types, codes and the command script table of the i2c master
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // command codes carried by the kind field
    localparam logic [3:0] KIND_NONE      = 4'd0;
    localparam logic [3:0] KIND_START     = 4'd1;
    localparam logic [3:0] KIND_STOP      = 4'd2;
    localparam logic [3:0] KIND_WRITE     = 4'd3;
    localparam logic [3:0] KIND_READ_ACK  = 4'd4;
    localparam logic [3:0] KIND_READ_NAK  = 4'd5;
    localparam logic [3:0] KIND_REG_WRITE = 4'd6;
    localparam logic [3:0] KIND_REG_READ  = 4'd7;
    localparam logic [3:0] KIND_PROBE     = 4'd8;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd5;
    localparam logic [7:0]  BIT_MSB           = 8'h80;
    localparam logic [7:0]  BIT_RW_READ       = 8'h01;

    typedef enum logic [3:0] {
        EL_END      = 4'd0,
        EL_START    = 4'd1,
        EL_STOP     = 4'd2,
        EL_WADDR    = 4'd3,
        EL_WADDR_RD = 4'd4,
        EL_WREG     = 4'd5,
        EL_WDATA    = 4'd6,
        EL_RACK     = 4'd7,
        EL_RNAK     = 4'd8
    } t_elem;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START0  = 4'd1,
        PH_START1  = 4'd2,
        PH_START2  = 4'd3,
        PH_START3  = 4'd4,
        PH_STOP0   = 4'd5,
        PH_STOP1   = 4'd6,
        PH_STOP2   = 4'd7,
        PH_BITLOW  = 4'd8,
        PH_BITHIGH = 4'd9
    } t_phase;

    typedef struct packed {
        logic [3:0] kind;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] write_data;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic       ack_ok;
        logic [7:0] read_data;
    } t_out_item;

    typedef struct packed {
        logic [3:0] kind;
        logic [6:0] dev;
        logic [7:0] reg_addr;
        logic [7:0] data;
    } t_cmd;

    // controller state other than the phase timer
    typedef struct packed {
        t_phase     phase;
        logic [3:0] bit_count;
        logic [7:0] shift_byte;
        logic [2:0] byte_step;
        logic       ack_flag;
        logic [7:0] received_byte;
        t_cmd       cmd;
        logic       scl_level;
        logic       sda_level;
    } t_state;

    // bus element at a given step of a command's script
    function automatic t_elem script_elem(input logic [3:0] kind, input logic [2:0] step);
        t_elem el;
        el = EL_END;
        unique case (kind)
            KIND_START:     if (step == 3'd0) el = EL_START;
            KIND_STOP:      if (step == 3'd0) el = EL_STOP;
            KIND_WRITE:     if (step == 3'd0) el = EL_WDATA;
            KIND_READ_ACK:  if (step == 3'd0) el = EL_RACK;
            KIND_READ_NAK:  if (step == 3'd0) el = EL_RNAK;
            KIND_REG_WRITE: begin
                unique case (step)
                    3'd0:    el = EL_START;
                    3'd1:    el = EL_WADDR;
                    3'd2:    el = EL_WREG;
                    3'd3:    el = EL_WDATA;
                    3'd4:    el = EL_STOP;
                    default: el = EL_END;
                endcase
            end
            KIND_REG_READ: begin
                unique case (step)
                    3'd0:    el = EL_START;
                    3'd1:    el = EL_WADDR;
                    3'd2:    el = EL_WREG;
                    3'd3:    el = EL_START;
                    3'd4:    el = EL_WADDR_RD;
                    3'd5:    el = EL_RNAK;
                    3'd6:    el = EL_STOP;
                    default: el = EL_END;
                endcase
            end
            KIND_PROBE: begin
                unique case (step)
                    3'd0:    el = EL_START;
                    3'd1:    el = EL_WADDR;
                    3'd2:    el = EL_STOP;
                    default: el = EL_END;
                endcase
            end
            default: el = EL_END;
        endcase
        return el;
    endfunction

    function automatic logic elem_reads(input t_elem el);
        return (el == EL_RACK) || (el == EL_RNAK);
    endfunction

endpackage

FILE: sv/i2cm_step.sv
// ----------------------------------------------------------------------------
// i2cm_step
// next-state logic of the i2c master for one tick
// ----------------------------------------------------------------------------
module i2cm_step #(
    parameter int TIMER_WIDTH = 16
) (
    input  i2cm_pkg::t_state   i_state,
    input  logic [TIMER_WIDTH-1:0] i_timer,
    input  i2cm_pkg::t_in_item i_item,
    input  logic [15:0]        i_half,
    output i2cm_pkg::t_state   o_state,
    output logic [TIMER_WIDTH-1:0] o_timer,
    output logic               o_done
);

    localparam logic [32:0] TIMER_MASK = (33'd1 << TIMER_WIDTH) - 33'd1;

    logic [15:0]            w_half_m1;
    logic [32:0]            w_half_ext;
    logic [TIMER_WIDTH-1:0] w_load;

    // zero half period is treated like a half period of one, saturate into a narrow timer
    always_comb begin
        w_half_m1  = (i_half == 16'd0) ? 16'd0 : (i_half - 16'd1);
        w_half_ext = {17'd0, w_half_m1};
        w_load     = (w_half_ext > TIMER_MASK) ? TIMER_MASK[TIMER_WIDTH-1:0]
                                               : w_half_ext[TIMER_WIDTH-1:0];
    end

    always_comb begin
        i2cm_pkg::t_state s;
        i2cm_pkg::t_elem  el_cur;
        i2cm_pkg::t_elem  el_new;
        i2cm_pkg::t_phase ph_target;
        logic             enter_el;
        logic             enter_ph;

        s         = i_state;
        o_timer   = i_timer;
        o_done    = 1'b0;
        enter_el  = 1'b0;
        enter_ph  = 1'b0;
        ph_target = i2cm_pkg::PH_IDLE;
        el_cur    = i2cm_pkg::script_elem(i_state.cmd.kind, i_state.byte_step);

        if (i_state.phase == i2cm_pkg::PH_IDLE) begin
            if (i_item.kind >= i2cm_pkg::KIND_START && i_item.kind <= i2cm_pkg::KIND_PROBE) begin
                s.cmd.kind     = i_item.kind;
                s.cmd.dev      = i_item.device_address;
                s.cmd.reg_addr = i_item.register_address;
                s.cmd.data     = i_item.write_data;
                s.ack_flag     = 1'b1;
                s.byte_step    = 3'd0;
                enter_el       = 1'b1;
            end
        end else if (i_timer != '0) begin
            o_timer = i_timer - TIMER_WIDTH'(1);
        end else begin
            unique case (i_state.phase)
                i2cm_pkg::PH_START3, i2cm_pkg::PH_STOP2: begin
                    s.byte_step = i_state.byte_step + 3'd1;
                    enter_el    = 1'b1;
                end
                i2cm_pkg::PH_BITLOW: begin
                    enter_ph  = 1'b1;
                    ph_target = i2cm_pkg::PH_BITHIGH;
                end
                i2cm_pkg::PH_BITHIGH: begin
                    if (i_state.bit_count < 4'd8) begin
                        if (i2cm_pkg::elem_reads(el_cur)) begin
                            s.shift_byte = {i_state.shift_byte[6:0], i_item.sda_in};
                        end
                    end else if (!i2cm_pkg::elem_reads(el_cur)) begin
                        s.ack_flag = i_state.ack_flag & ~i_item.sda_in;
                    end
                    s.bit_count = i_state.bit_count + 4'd1;
                    if (s.bit_count < 4'd9) begin
                        enter_ph  = 1'b1;
                        ph_target = i2cm_pkg::PH_BITLOW;
                    end else begin
                        s.scl_level = 1'b0;
                        if (i2cm_pkg::elem_reads(el_cur)) begin
                            s.received_byte = s.shift_byte;
                        end
                        s.byte_step = i_state.byte_step + 3'd1;
                        enter_el    = 1'b1;
                    end
                end
                i2cm_pkg::PH_START0: begin enter_ph = 1'b1; ph_target = i2cm_pkg::PH_START1; end
                i2cm_pkg::PH_START1: begin enter_ph = 1'b1; ph_target = i2cm_pkg::PH_START2; end
                i2cm_pkg::PH_START2: begin enter_ph = 1'b1; ph_target = i2cm_pkg::PH_START3; end
                i2cm_pkg::PH_STOP0:  begin enter_ph = 1'b1; ph_target = i2cm_pkg::PH_STOP1;  end
                i2cm_pkg::PH_STOP1:  begin enter_ph = 1'b1; ph_target = i2cm_pkg::PH_STOP2;  end
                default: begin enter_ph = 1'b1; ph_target = i2cm_pkg::PH_IDLE; end
            endcase
        end

        // start the next bus element of the script
        el_new = i2cm_pkg::script_elem(s.cmd.kind, s.byte_step);
        if (enter_el) begin
            unique case (el_new)
                i2cm_pkg::EL_START: begin enter_ph = 1'b1; ph_target = i2cm_pkg::PH_START0; end
                i2cm_pkg::EL_STOP:  begin enter_ph = 1'b1; ph_target = i2cm_pkg::PH_STOP0;  end
                i2cm_pkg::EL_END: begin
                    s.phase = i2cm_pkg::PH_IDLE;
                    o_timer = '0;
                    o_done  = 1'b1;
                end
                default: begin
                    s.bit_count = 4'd0;
                    unique case (el_new)
                        i2cm_pkg::EL_WADDR:    s.shift_byte = {s.cmd.dev, 1'b0};
                        i2cm_pkg::EL_WADDR_RD: s.shift_byte = {s.cmd.dev, 1'b0}
                                                              | i2cm_pkg::BIT_RW_READ;
                        i2cm_pkg::EL_WREG:     s.shift_byte = s.cmd.reg_addr;
                        i2cm_pkg::EL_WDATA:    s.shift_byte = s.cmd.data;
                        default:               s.shift_byte = 8'd0;
                    endcase
                    enter_ph  = 1'b1;
                    ph_target = i2cm_pkg::PH_BITLOW;
                end
            endcase
        end

        // drive the line levels of the phase being entered
        if (enter_ph) begin
            s.phase = ph_target;
            unique case (ph_target)
                i2cm_pkg::PH_START0: s.sda_level = 1'b1;
                i2cm_pkg::PH_START1: s.scl_level = 1'b1;
                i2cm_pkg::PH_START2: s.sda_level = 1'b0;
                i2cm_pkg::PH_START3: s.scl_level = 1'b0;
                i2cm_pkg::PH_STOP0: begin
                    s.scl_level = 1'b0;
                    s.sda_level = 1'b0;
                end
                i2cm_pkg::PH_STOP1:  s.scl_level = 1'b1;
                i2cm_pkg::PH_STOP2:  s.sda_level = 1'b1;
                i2cm_pkg::PH_BITLOW: begin
                    s.scl_level = 1'b0;
                    if (s.bit_count < 4'd8) begin
                        s.sda_level = i2cm_pkg::elem_reads(el_new) ? 1'b1
                            : ((s.shift_byte & (i2cm_pkg::BIT_MSB >> s.bit_count[2:0])) != 8'd0);
                    end else begin
                        s.sda_level = (el_new == i2cm_pkg::EL_RACK) ? 1'b0 : 1'b1;
                    end
                end
                default: s.scl_level = 1'b1;
            endcase
            o_timer = w_load;
        end

        o_state = s;
    end

endmodule

FILE: sv/i2c_master_transactions.sv
// ----------------------------------------------------------------------------
// i2c_master_transactions
// tick-driven i2c bus master with scripted register and probe commands
// ----------------------------------------------------------------------------
// Each input transaction is one tick of the bus timing base and may carry a
// command (start, stop, write byte, read with ack or nak, register write,
// register read with repeated start, address probe). Every accepted input
// transaction yields exactly one output transaction with the scl/sda drive
// levels (1 = released), busy, a one-tick done pulse, the acknowledge summary
// and the last read byte. Commands arriving while busy are ignored. Rate: one
// transaction per clock while i_out_ready holds; each result passes the input
// register, the combinational step logic and the output register, and a stall
// on the output holds it. half_period_ticks is written through i_cfg_we /
// i_cfg_data and must only change while no command is running.
module i2c_master_transactions #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input transactions
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  i2cm_pkg::t_in_item    i_in_item,
    // output transactions
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output i2cm_pkg::t_out_item   o_out_item,
    // configuration write
    input  logic                  i_cfg_we,
    input  logic [15:0]           i_cfg_data
);

    // input register
    logic               r_in_valid;
    i2cm_pkg::t_in_item r_in_item;

    // controller state
    i2cm_pkg::t_state       r_state, n_state;
    logic [TIMER_WIDTH-1:0] r_timer, n_timer;
    logic                   w_done;

    // configuration
    logic [15:0] r_half;

    // output register
    logic                r_out_valid;
    i2cm_pkg::t_out_item r_out_item, n_out_item;

    // one tick moves when an input is held and the output slot is free or being drained
    logic w_advance;

    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= i2cm_pkg::HALF_PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_half <= i_cfg_data;
        end
    end

    // tick logic
    i2cm_step #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_step (
        .i_state (r_state),
        .i_timer (r_timer),
        .i_item  (r_in_item),
        .i_half  (r_half),
        .o_state (n_state),
        .o_timer (n_timer),
        .o_done  (w_done)
    );

    // state updates only when a tick's result goes to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= i2cm_pkg::PH_IDLE;
            r_state.bit_count     <= 4'd0;
            r_state.shift_byte    <= 8'd0;
            r_state.byte_step     <= 3'd0;
            r_state.ack_flag      <= 1'b0;
            r_state.received_byte <= 8'd0;
            r_state.cmd           <= '0;
            r_state.scl_level     <= 1'b1;
            r_state.sda_level     <= 1'b1;
            r_timer               <= '0;
        end else if (w_advance) begin
            r_state <= n_state;
            r_timer <= n_timer;
        end
    end

    // result of this tick
    always_comb begin
        n_out_item.scl_out   = n_state.scl_level;
        n_out_item.sda_out   = n_state.sda_level;
        n_out_item.busy_res  = (n_state.phase != i2cm_pkg::PH_IDLE);
        n_out_item.done_res  = w_done;
        n_out_item.ack_ok    = n_state.ack_flag;
        n_out_item.read_data = n_state.received_byte;
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_item <= n_out_item;
        end
    end

`ifndef SYNTHESIS
    // a completing command leaves the block idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_item.done_res |-> !r_out_item.busy_res)
        else $error("done reported while still busy");

    // the phase timer is cleared whenever the block is idle
    a_idle_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == i2cm_pkg::PH_IDLE |-> r_timer == '0)
        else $error("timer running while idle");

    // state only moves with a tick that produces a result
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_state) && $stable(r_timer))
        else $error("state changed without a tick");

    // bit phases count at most eight data bits and the ack bit
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase == i2cm_pkg::PH_BITLOW || r_state.phase == i2cm_pkg::PH_BITHIGH)
        |-> r_state.bit_count <= 4'd8)
        else $error("bit counter out of range");
`endif

endmodule
